@@ src/etb_pkg.sv @@
// Package for the event timer bank.
// Holds operation codes, the timer entry type and the sequencer state type.
// No dependencies.
package etb_pkg;

    localparam int DEF_NUM_TIMERS = 8;
    localparam logic [15:0] RESET_PERIOD = 16'd1024;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_SET   = 3'd1;
    localparam logic [2:0] OP_READ  = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_POLL  = 3'd4;
    localparam logic [2:0] OP_TIME  = 3'd5;

    typedef struct packed {
        logic [15:0] count;
        logic [15:0] reload;
    } timer_ent_t;

    typedef struct packed {
        logic [15:0] count_next;
        logic        fire;
    } step_res_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RD   = 3'b010,
        ST_WR   = 3'b100
    } state_t;

endpackage

@@ src/etb_step_unit.sv @@
// Shared decrement and reload unit of the event timer bank.
// Depends on etb_pkg for the entry and result types.
module etb_step_unit
    import etb_pkg::*;
(
    input  timer_ent_t ent,
    output step_res_t  res
);

    always_comb
    begin
        if (ent.count != 16'd0)
        begin
            res.count_next = ent.count - 16'd1;
            res.fire       = 1'b0;
        end
        else
        begin
            res.count_next = ent.reload;
            res.fire       = 1'b1;
        end
    end

endmodule

@@ src/etb_timer_mem.sv @@
// Count and period memory of the event timer bank, with per-entry valid bits.
// Depends on etb_pkg for the entry type and the reset period.
module etb_timer_mem
    import etb_pkg::*;
#(
    parameter int NUM_TIMERS = DEF_NUM_TIMERS,
    parameter int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  timer_ent_t       wdata,
    input  logic [IDX_W-1:0] raddr,
    output timer_ent_t       rdata
);

    timer_ent_t            mem [NUM_TIMERS];
    timer_ent_t            rdata_reg;
    logic                  rvld_reg;
    logic [NUM_TIMERS-1:0] vld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            rvld_reg <= vld_reg[raddr];
        end
    end

    // An entry never written since reset reads as the reset period.
    assign rdata = rvld_reg ? rdata_reg
                            : timer_ent_t'{count: RESET_PERIOD, reload: RESET_PERIOD};

endmodule

@@ src/event_timer_bank_core.sv @@
// Top level of the event timer bank: sequencer, flags and tick counter.
// Depends on etb_pkg, etb_timer_mem and etb_step_unit.
//
// Usage: drive op, timer_id and period and raise start; the word is taken
// at a rising edge where start is high and busy is low. Every word gives
// exactly one result word on flag and time_res, marked by done for one
// cycle. The receiver cannot stall, so results are never held back.
// Short words: set period, read flag, clear flag, poll and clear, read
// time and unused codes finish with done rising right after the accepting
// edge, and busy stays low, so one such word can be taken every cycle.
// A tick walks the timers one at a time through one shared decrement
// unit, reading each timer from memory and then writing it back, with
// busy high throughout and done in the cycle after the last write.
// Reset: every count and period reads as 1024, every flag is clear, the
// time is zero and the block is idle. No clearing pass is needed.
module event_timer_bank_core
    import etb_pkg::*;
#(
    parameter int NUM_TIMERS = DEF_NUM_TIMERS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [2:0]  timer_id,
    input  logic [15:0] period,
    output logic        done,
    output logic        flag,
    output logic [31:0] time_res
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [31:0]           ticks_reg, ticks_next;
    logic [NUM_TIMERS-1:0] expired_reg, expired_next;
    logic                  done_reg, done_next;
    logic                  flag_reg, flag_next;
    logic [31:0]           time_reg, time_next;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    timer_ent_t            mem_wdata;
    timer_ent_t            rd_ent;
    step_res_t             step;

    logic                  id_ok;
    logic [IDX_W-1:0]      id_idx;

    assign id_ok  = (32'(timer_id) < NUM_TIMERS);
    assign id_idx = IDX_W'(timer_id);

    etb_timer_mem #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IDX_W)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (idx_reg),
        .rdata (rd_ent)
    );

    etb_step_unit u_step (
        .ent (rd_ent),
        .res (step)
    );

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        ticks_next   = ticks_reg;
        expired_next = expired_reg;
        done_next    = 1'b0;
        flag_next    = flag_reg;
        time_next    = time_reg;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg;
        mem_wdata    = '{count: period, reload: period};

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    flag_next = 1'b0;
                    time_next = ticks_reg;
                    done_next = (op != OP_TICK);
                    case (op)
                        OP_TICK:
                        begin
                            state_next = ST_RD;
                            idx_next   = '0;
                        end
                        OP_SET:
                        begin
                            if (id_ok)
                            begin
                                mem_we               = 1'b1;
                                mem_waddr            = id_idx;
                                expired_next[id_idx] = 1'b0;
                            end
                        end
                        OP_READ:
                        begin
                            if (id_ok)
                            begin
                                flag_next = expired_reg[id_idx];
                            end
                        end
                        OP_CLEAR:
                        begin
                            if (id_ok)
                            begin
                                expired_next[id_idx] = 1'b0;
                            end
                        end
                        OP_POLL:
                        begin
                            if (id_ok)
                            begin
                                flag_next            = expired_reg[id_idx];
                                expired_next[id_idx] = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = '{count: step.count_next, reload: rd_ent.reload};
                if (step.fire)
                begin
                    expired_next[idx_reg] = 1'b1;
                end
                if (idx_reg == LAST_IDX)
                begin
                    ticks_next = ticks_reg + 32'd1;
                    time_next  = ticks_reg + 32'd1;
                    flag_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            ticks_reg   <= '0;
            expired_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            ticks_reg   <= ticks_next;
            expired_reg <= expired_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flag_reg <= flag_next;
        time_reg <= time_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign flag     = flag_reg;
    assign time_res = time_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word shown while busy");

    a_short_op_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op != OP_TICK) |=> done)
        else $error("single-cycle operation gave no result word");

    a_tick_time: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR && idx_reg == LAST_IDX)
        |=> (done && time_res == ticks_reg && ticks_reg == $past(ticks_reg) + 32'd1))
        else $error("tick did not advance the time by one");

endmodule

@@ tb/event_timer_bank_core_tb.sv @@
// Self-checking testbench for event_timer_bank_core: directed and random operation words
// against a behavioral model of the timer bank, with random start gaps.
// Depends on etb_pkg and event_timer_bank_core.
module event_timer_bank_core_tb;
    import etb_pkg::*;

    localparam int TIMERS = DEF_NUM_TIMERS;
    localparam int SETTLE_CYCLES = 2 * TIMERS + 4;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    typedef struct {
        logic        flag;
        logic [31:0] time_res;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  op = OP_TIME;
    logic [2:0]  timer_id = 3'd0;
    logic [15:0] period = 16'd0;
    logic        busy;
    logic        done;
    logic        flag;
    logic [31:0] time_res;

    logic [15:0] timer_count [TIMERS];
    logic [15:0] timer_reload [TIMERS];
    logic        timer_flag [TIMERS];
    logic [31:0] tick_total;

    reply_t pending_q [$];
    reply_t head_reply;
    int     errors = 0;
    bit     gaps_on = 1'b1;

    event_timer_bank_core #(
        .NUM_TIMERS(TIMERS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .op       (op),
        .timer_id (timer_id),
        .period   (period),
        .done     (done),
        .flag     (flag),
        .time_res (time_res)
    );

    always #5 clk = ~clk;

    task automatic clear_bank_model();
        for (int i = 0; i < TIMERS; i++)
        begin
            timer_count[i] = RESET_PERIOD;
            timer_reload[i] = RESET_PERIOD;
            timer_flag[i] = 1'b0;
        end
        tick_total = 32'd0;
    endtask

    function automatic reply_t apply_word(input logic [2:0] code, input logic [2:0] id,
                                          input logic [15:0] per);
        reply_t r;
        bit     hit;
        r.flag = 1'b0;
        hit = int'(id) < TIMERS;
        case (code)
            OP_TICK:
            begin
                for (int i = 0; i < TIMERS; i++)
                begin
                    if (timer_count[i] != 16'd0)
                    begin
                        timer_count[i] = timer_count[i] - 16'd1;
                    end
                    else
                    begin
                        timer_count[i] = timer_reload[i];
                        timer_flag[i] = 1'b1;
                    end
                end
                tick_total = tick_total + 32'd1;
            end
            OP_SET:
            begin
                if (hit)
                begin
                    timer_count[id] = per;
                    timer_reload[id] = per;
                    timer_flag[id] = 1'b0;
                end
            end
            OP_READ:
            begin
                if (hit)
                begin
                    r.flag = timer_flag[id];
                end
            end
            OP_CLEAR:
            begin
                if (hit)
                begin
                    timer_flag[id] = 1'b0;
                end
            end
            OP_POLL:
            begin
                if (hit)
                begin
                    r.flag = timer_flag[id];
                    timer_flag[id] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        r.time_res = tick_total;
        return r;
    endfunction

    // Start stays high after a word is taken so that the next word can follow at once.
    task automatic send_word(input logic [2:0] code, input logic [2:0] id,
                             input logic [15:0] per);
        while (gaps_on && $urandom_range(0, 99) < 37)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        op <= code;
        timer_id <= id;
        period <= per;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_q.push_back(apply_word(code, id, per));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_q.size() != 0);
    endtask

    function automatic logic [2:0] pick_op(input int tick_pct, input bit allow_set);
        logic [2:0] code;
        if ($urandom_range(0, 99) < tick_pct)
        begin
            return OP_TICK;
        end
        case ($urandom_range(0, 10))
            0, 1, 2: code = allow_set ? OP_SET : OP_READ;
            3, 4:    code = OP_READ;
            5:       code = OP_CLEAR;
            6, 7:    code = OP_POLL;
            8:       code = OP_TIME;
            9:       code = OP_SPARE6;
            default: code = OP_SPARE7;
        endcase
        return code;
    endfunction

    // Short periods keep the flags firing often; one in four spans the full range.
    function automatic logic [15:0] pick_period();
        if ($urandom_range(0, 3) == 0)
        begin
            return 16'($urandom);
        end
        return 16'($urandom_range(0, 6));
    endfunction

    function automatic logic [2:0] pick_id();
        return 3'($urandom_range(0, TIMERS - 1));
    endfunction

    task automatic test_reset_state();
        send_word(OP_TIME, 3'd0, 16'h0000);
        send_word(OP_READ, 3'd7, 16'hFFFF);
        send_word(OP_POLL, 3'd5, 16'h0000);
    endtask

    task automatic test_set_and_fire();
        send_word(OP_SET, 3'd0, 16'h0000);
        send_word(OP_SET, 3'd1, 16'hFFFF);
        send_word(OP_SET, 3'd2, 16'h0001);
        send_word(OP_SET, 3'd3, 16'h0002);
        send_word(OP_TICK, 3'd7, 16'hFFFF);
        send_word(OP_READ, 3'd0, 16'h0000);
        send_word(OP_TICK, 3'd0, 16'h0000);
        send_word(OP_READ, 3'd2, 16'h0000);
        send_word(OP_READ, 3'd1, 16'h0000);
    endtask

    task automatic test_flag_ops();
        send_word(OP_POLL, 3'd0, 16'h0000);
        send_word(OP_POLL, 3'd0, 16'h0000);
        send_word(OP_CLEAR, 3'd2, 16'h0000);
        send_word(OP_READ, 3'd2, 16'h0000);
        send_word(OP_TICK, 3'd3, 16'h5555);
        send_word(OP_READ, 3'd3, 16'h0000);
        send_word(OP_SET, 3'd0, 16'hAAAA);
        send_word(OP_READ, 3'd0, 16'h0000);
    endtask

    task automatic test_unused_ops();
        send_word(OP_SPARE6, 3'd0, 16'hFFFF);
        send_word(OP_SPARE7, 3'd7, 16'h0000);
        send_word(OP_TIME, 3'd3, 16'h1234);
        send_word(OP_READ, 3'd3, 16'h0000);
    endtask

    // Timers 4 to 7 keep their reset period here, so they fire on the 1025th tick since reset.
    task automatic test_reset_reload();
        int         ticks_sent;
        logic [2:0] code;
        ticks_sent = 0;
        while (ticks_sent < int'(RESET_PERIOD) + 6)
        begin
            code = pick_op(90, 1'b0);
            if (code == OP_TICK)
            begin
                ticks_sent++;
            end
            send_word(code, pick_id(), 16'($urandom));
        end
    endtask

    task automatic test_random_mix(input int words);
        logic [2:0] code;
        for (int n = 0; n < words; n++)
        begin
            code = pick_op(40, 1'b1);
            send_word(code, pick_id(), code == OP_SET ? pick_period() : 16'($urandom));
        end
    endtask

    task automatic test_back_to_back(input int words);
        logic [2:0] code;
        gaps_on = 1'b0;
        for (int n = 0; n < words; n++)
        begin
            code = pick_op(15, 1'b1);
            send_word(code, pick_id(), code == OP_SET ? pick_period() : 16'($urandom));
        end
        gaps_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual flag %0b time %0d",
                         $time, flag, time_res);
                errors++;
            end
            else
            begin
                head_reply = pending_q.pop_front();
                if (flag !== head_reply.flag)
                begin
                    $display("%0t: flag mismatch, expected %0b, actual %0b",
                             $time, head_reply.flag, flag);
                    errors++;
                end
                if (time_res !== head_reply.time_res)
                begin
                    $display("%0t: time mismatch, expected %0d, actual %0d",
                             $time, head_reply.time_res, time_res);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        clear_bank_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_set_and_fire();
        test_flag_ops();
        test_unused_ops();
        wait_drained();
        test_reset_reload();
        wait_drained();
        test_random_mix(300);
        wait_drained();
        test_back_to_back(150);
        test_random_mix(30);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
